/* hw/rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion macros for the point light direction block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define PLD_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define PLD_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);
`else
`define PLD_ASSERT(label, clk, rst_n, prop, msg)
`define PLD_ASSERT_NEXT(label, clk, rst_n, pre, post, msg)
`endif
`endif

/* hw/rtl/pld_pkg.sv */
// ----------------------------------------------------------------------------
// Point light direction package
// Constants and register indexes shared by the direction pipeline.
// ----------------------------------------------------------------------------
package pld_pkg;

    localparam int OUT_FRAC_BITS_DEF = 14;
    localparam int COORD_W           = 32;
    localparam int DIR_W             = 16;
    localparam int CFG_IDX_W         = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LIGHT_X = 2'd0,
        CFG_LIGHT_Y = 2'd1,
        CFG_LIGHT_Z = 2'd2
    } cfg_index_t;

endpackage

/* hw/rtl/pld_root_step.sv */
// ----------------------------------------------------------------------------
// Root step
// One bit of the scaled reciprocal root search for one component.
// ----------------------------------------------------------------------------
module pld_root_step
    import pld_pkg::*;
#(
    parameter int OUT_FRAC_BITS = OUT_FRAC_BITS_DEF,
    parameter int BIT           = 0,
    parameter int W             = 2 * OUT_FRAC_BITS_DEF + 74,
    parameter int TW            = OUT_FRAC_BITS_DEF + 2
)
(
    input  logic          clk,
    input  logic          en,
    input  logic [W-1:0]  s_in,
    input  logic [W-1:0]  r_in,
    input  logic [W-1:0]  p_in,
    input  logic [W-1:0]  q_in,
    input  logic [TW-1:0] t_in,
    output logic [W-1:0]  s_out,
    output logic [W-1:0]  r_out,
    output logic [W-1:0]  p_out,
    output logic [W-1:0]  q_out,
    output logic [TW-1:0] t_out
);

    logic [W-1:0]  cand_p;
    logic          take;
    logic [W-1:0]  s_reg;
    logic [W-1:0]  r_reg;
    logic [W-1:0]  p_reg;
    logic [W-1:0]  q_reg;
    logic [TW-1:0] t_reg;

    // The running values are t*t*S and t*S, so a trial bit needs only shifts and adds.
    always_comb
    begin
        cand_p = p_in + (q_in << (BIT + 1)) + (s_in << (2 * BIT));
        take   = (cand_p <= r_in);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s_reg <= s_in;
            r_reg <= r_in;
            if (take)
            begin
                p_reg <= cand_p;
                q_reg <= q_in + (s_in << BIT);
                t_reg <= t_in | (TW'(1) << BIT);
            end
            else
            begin
                p_reg <= p_in;
                q_reg <= q_in;
                t_reg <= t_in;
            end
        end
    end

    assign s_out = s_reg;
    assign r_out = r_reg;
    assign p_out = p_reg;
    assign q_out = q_reg;
    assign t_out = t_reg;

endmodule

/* hw/rtl/point_light_direction.sv */
// Throughput: one transaction per cycle; every stage advances whenever the output
// register is empty or being taken, one root bit per stage for all three axes.
// Reset clears the light position and all valid bits; no clearing pass is needed.
// ----------------------------------------------------------------------------
// Point light direction
// Unit vector from a surface point towards a configured point light.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module point_light_direction
    import pld_pkg::*;
#(
    parameter int OUT_FRAC_BITS = OUT_FRAC_BITS_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_write,
    input  logic [CFG_IDX_W-1:0]      cfg_index,
    input  logic [COORD_W-1:0]        cfg_data,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic signed [COORD_W-1:0] shape_x,
    input  logic signed [COORD_W-1:0] shape_y,
    input  logic signed [COORD_W-1:0] shape_z,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic signed [DIR_W-1:0]   dir_x,
    output logic signed [DIR_W-1:0]   dir_y,
    output logic signed [DIR_W-1:0]   dir_z,
    output logic                      zero_length
);

    localparam int NB = OUT_FRAC_BITS + 2;
    localparam int TW = OUT_FRAC_BITS + 2;
    localparam int W  = 2 * OUT_FRAC_BITS + 74;
    localparam int RW = (TW + 1 > DIR_W) ? TW + 1 : DIR_W;

    logic en;

    logic [COORD_W-1:0] light_reg [0:2];

    logic [COORD_W:0]   diff [0:2];
    logic               a_valid_reg;
    logic [COORD_W-1:0] a_mag_reg [0:2];
    logic [2:0]         a_neg_reg;

    logic               b_valid_reg;
    logic [2*COORD_W-1:0] b_sq_reg [0:2];
    logic [2:0]         b_neg_reg;

    logic               c_valid_reg;
    logic [W-1:0]       c_s_reg;
    logic [W-1:0]       c_r_reg [0:2];
    logic [2:0]         c_neg_reg;
    logic               c_zero_reg;
    logic [W-1:0]       c_sum;

    logic [W-1:0]  s_p [0:2][0:NB];
    logic [W-1:0]  r_p [0:2][0:NB];
    logic [W-1:0]  p_p [0:2][0:NB];
    logic [W-1:0]  q_p [0:2][0:NB];
    logic [TW-1:0] t_p [0:2][0:NB];
    logic          v_reg [1:NB];
    logic [2:0]    neg_reg [1:NB];
    logic          zero_reg [1:NB];

    logic [RW-1:0]    rnd [0:2];
    logic [RW-1:0]    res [0:2];
    logic             o_valid_reg;
    logic [DIR_W-1:0] o_dir_reg [0:2];
    logic             o_zero_reg;

    assign en       = !o_valid_reg || out_ready;
    assign in_ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            light_reg[0] <= '0;
            light_reg[1] <= '0;
            light_reg[2] <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_LIGHT_X: light_reg[0] <= cfg_data;
                CFG_LIGHT_Y: light_reg[1] <= cfg_data;
                CFG_LIGHT_Z: light_reg[2] <= cfg_data;
                default:     ;
            endcase
        end
    end

    always_comb
    begin
        diff[0] = {light_reg[0][COORD_W-1], light_reg[0]} - {shape_x[COORD_W-1], shape_x};
        diff[1] = {light_reg[1][COORD_W-1], light_reg[1]} - {shape_y[COORD_W-1], shape_y};
        diff[2] = {light_reg[2][COORD_W-1], light_reg[2]} - {shape_z[COORD_W-1], shape_z};
        c_sum   = W'(b_sq_reg[0]) + W'(b_sq_reg[1]) + W'(b_sq_reg[2]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            a_valid_reg <= in_valid;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                a_neg_reg[i] <= diff[i][COORD_W];
                a_mag_reg[i] <= diff[i][COORD_W] ? COORD_W'(-diff[i]) : diff[i][COORD_W-1:0];
                b_sq_reg[i]  <= a_mag_reg[i] * a_mag_reg[i];
                c_r_reg[i]   <= W'(b_sq_reg[i]) << (2 * OUT_FRAC_BITS + 2);
            end
            b_neg_reg  <= a_neg_reg;
            c_neg_reg  <= b_neg_reg;
            c_s_reg    <= c_sum;
            c_zero_reg <= (c_sum == '0);
        end
    end

    genvar gl, gk;
    generate
        for (gl = 0; gl < 3; gl++)
        begin : g_lane
            assign s_p[gl][0] = c_s_reg;
            assign r_p[gl][0] = c_r_reg[gl];
            assign p_p[gl][0] = '0;
            assign q_p[gl][0] = '0;
            assign t_p[gl][0] = '0;
            for (gk = 0; gk < NB; gk++)
            begin : g_step
                pld_root_step #(
                    .OUT_FRAC_BITS (OUT_FRAC_BITS),
                    .BIT           (NB - 1 - gk),
                    .W             (W),
                    .TW            (TW)
                ) u_step (
                    .clk   (clk),
                    .en    (en),
                    .s_in  (s_p[gl][gk]),
                    .r_in  (r_p[gl][gk]),
                    .p_in  (p_p[gl][gk]),
                    .q_in  (q_p[gl][gk]),
                    .t_in  (t_p[gl][gk]),
                    .s_out (s_p[gl][gk+1]),
                    .r_out (r_p[gl][gk+1]),
                    .p_out (p_p[gl][gk+1]),
                    .q_out (q_p[gl][gk+1]),
                    .t_out (t_p[gl][gk+1])
                );
            end
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 1; k <= NB; k++)
            begin
                v_reg[k] <= 1'b0;
            end
            o_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            v_reg[1] <= c_valid_reg;
            for (int k = 2; k <= NB; k++)
            begin
                v_reg[k] <= v_reg[k-1];
            end
            o_valid_reg <= v_reg[NB];
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            rnd[i] = (RW'(t_p[i][NB]) + RW'(1)) >> 1;
            res[i] = neg_reg[NB][i] ? -rnd[i] : rnd[i];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            neg_reg[1]  <= c_neg_reg;
            zero_reg[1] <= c_zero_reg;
            for (int k = 2; k <= NB; k++)
            begin
                neg_reg[k]  <= neg_reg[k-1];
                zero_reg[k] <= zero_reg[k-1];
            end
            for (int i = 0; i < 3; i++)
            begin
                o_dir_reg[i] <= zero_reg[NB] ? '0 : res[i][DIR_W-1:0];
            end
            o_zero_reg <= zero_reg[NB];
        end
    end

    assign out_valid   = o_valid_reg;
    assign dir_x       = o_dir_reg[0];
    assign dir_y       = o_dir_reg[1];
    assign dir_z       = o_dir_reg[2];
    assign zero_length = o_zero_reg;

    `PLD_ASSERT(a_ready_follows_output, clk, rst_n, (in_ready == (!out_valid || out_ready)), "Input ready does not follow the output slot.")
    `PLD_ASSERT_NEXT(a_accept_enters, clk, rst_n, (in_valid && in_ready), a_valid_reg, "Accepted transaction did not enter the pipeline.")
    `PLD_ASSERT(a_zero_gives_zero, clk, rst_n, (out_valid && zero_length) |-> (dir_x == '0 && dir_y == '0 && dir_z == '0), "Zero length result has non-zero components.")

endmodule

/* bench/point_light_direction_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Point light direction testbench
// Streams surface points through the block under several light positions and
// randomised handshake pressure on both sides. Each result is checked against
// an exact fixed-point prediction of the normalised vector towards the light.
// ----------------------------------------------------------------------------

import pld_pkg::*;

typedef struct packed {
    logic [DIR_W-1:0] dx;
    logic [DIR_W-1:0] dy;
    logic [DIR_W-1:0] dz;
    logic             zero;
} light_dir_t;

class light_dir_scoreboard;
    light_dir_t pending[$];
    logic [COORD_W-1:0] light[3];
    int mismatches;
    int points_seen;
    int results_seen;
    int zero_seen;

    function new();
        light[0] = '0;
        light[1] = '0;
        light[2] = '0;
        mismatches = 0;
        points_seen = 0;
        results_seen = 0;
        zero_seen = 0;
    endfunction

    // Largest t with t^2 * sum <= a^2 * 2^(2F+2), then halved with rounding.
    function logic [DIR_W-1:0] unit_component(longint a, logic [127:0] sum);
        logic [127:0] limit;
        logic [127:0] prod;
        logic [127:0] cand;
        logic [127:0] t;
        t = '0;
        limit = (128'(a) * 128'(a)) << (2 * OUT_FRAC_BITS_DEF + 2);
        for (int b = OUT_FRAC_BITS_DEF + 1; b >= 0; b--)
        begin
            cand = t | (128'(1) << b);
            prod = cand * cand * sum;
            if (prod <= limit)
                t = cand;
        end
        t = (t + 1) >> 1;
        return t[DIR_W-1:0];
    endfunction

    function void note_point(logic [COORD_W-1:0] sx, logic [COORD_W-1:0] sy,
                             logic [COORD_W-1:0] sz);
        longint diff[3];
        longint mag[3];
        logic [127:0] sum;
        logic [DIR_W-1:0] c[3];
        light_dir_t e;
        diff[0] = longint'($signed(light[0])) - longint'($signed(sx));
        diff[1] = longint'($signed(light[1])) - longint'($signed(sy));
        diff[2] = longint'($signed(light[2])) - longint'($signed(sz));
        sum = '0;
        for (int i = 0; i < 3; i++)
        begin
            mag[i] = diff[i] < 0 ? -diff[i] : diff[i];
            sum = sum + 128'(mag[i]) * 128'(mag[i]);
        end
        if (sum == 0)
        begin
            e = '{dx: '0, dy: '0, dz: '0, zero: 1'b1};
        end
        else
        begin
            for (int i = 0; i < 3; i++)
            begin
                c[i] = unit_component(mag[i], sum);
                if (diff[i] < 0)
                    c[i] = -c[i];
            end
            e = '{dx: c[0], dy: c[1], dz: c[2], zero: 1'b0};
        end
        pending.push_back(e);
        points_seen++;
    endfunction

    task report(string what, logic [DIR_W-1:0] got, logic [DIR_W-1:0] want);
        $display("mismatch on %s at %0t: got %h, expected %h", what, $realtime, got, want);
        mismatches++;
    endtask

    task check_result(light_dir_t got);
        light_dir_t want;
        if (pending.size() == 0)
        begin
            $display("unexpected result transaction at %0t", $realtime);
            mismatches++;
            return;
        end
        want = pending.pop_front();
        results_seen++;
        if (want.zero)
            zero_seen++;
        if (got.dx !== want.dx)
            report("dir_x", got.dx, want.dx);
        if (got.dy !== want.dy)
            report("dir_y", got.dy, want.dy);
        if (got.dz !== want.dz)
            report("dir_z", got.dz, want.dz);
        if (got.zero !== want.zero)
            report("zero_length", got.zero, want.zero);
    endtask
endclass

module point_light_direction_test;
    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_LIGHT_X;
    logic [COORD_W-1:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic signed [COORD_W-1:0] shape_x = '0;
    logic signed [COORD_W-1:0] shape_y = '0;
    logic signed [COORD_W-1:0] shape_z = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic signed [DIR_W-1:0] dir_x;
    logic signed [DIR_W-1:0] dir_y;
    logic signed [DIR_W-1:0] dir_z;
    logic zero_length;

    light_dir_scoreboard sb = new();
    int sender_idle_pct = 18;
    int receiver_idle_pct = 47;
    int quiet_cycles = 0;
    localparam int QUIET_LIMIT = 5000;

    point_light_direction i_dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready),
        .shape_x(shape_x), .shape_y(shape_y), .shape_z(shape_z),
        .out_valid(out_valid), .out_ready(out_ready),
        .dir_x(dir_x), .dir_y(dir_y), .dir_z(dir_z), .zero_length(zero_length)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(negedge clk)
        out_ready <= rst_n && ($urandom_range(99) >= receiver_idle_pct);

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_result('{dx: dir_x, dy: dir_y, dz: dir_z, zero: zero_length});
        if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    task send_point(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y, logic [COORD_W-1:0] z);
        @(negedge clk);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        shape_x <= x;
        shape_y <= y;
        shape_z <= z;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_point(x, y, z);
    endtask

    task drain_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
    endtask

    task write_light(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y, logic [COORD_W-1:0] z);
        drain_results();
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= CFG_LIGHT_X;
        cfg_data <= x;
        @(negedge clk);
        cfg_index <= CFG_LIGHT_Y;
        cfg_data <= y;
        @(negedge clk);
        cfg_index <= CFG_LIGHT_Z;
        cfg_data <= z;
        @(negedge clk);
        cfg_write <= 1'b0;
        sb.light[0] = x;
        sb.light[1] = y;
        sb.light[2] = z;
    endtask

    function logic [COORD_W-1:0] near(logic [COORD_W-1:0] c);
        case ($urandom_range(3))
            0: return c + $urandom_range(65536 * 4) - 65536 * 2;
            1: return c + $urandom_range(16) - 8;
            2: return c;
            default: return $urandom;
        endcase
    endfunction

    task random_points(int count);
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] z;
        for (int n = 0; n < count; n++)
        begin
            case ($urandom_range(9))
                0, 1, 2:
                begin
                    x = $urandom;
                    y = $urandom;
                    z = $urandom;
                end
                3:
                begin
                    x = sb.light[0];
                    y = sb.light[1];
                    z = sb.light[2];
                end
                default:
                begin
                    x = near(sb.light[0]);
                    y = near(sb.light[1]);
                    z = near(sb.light[2]);
                end
            endcase
            send_point(x, y, z);
        end
    endtask

    localparam logic [COORD_W-1:0] MAXC = 32'h7fff_ffff;
    localparam logic [COORD_W-1:0] MINC = 32'h8000_0000;
    localparam logic [COORD_W-1:0] ONE  = 32'h0001_0000;

    initial
    begin
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed points against the reset light position at the origin.
        send_point('0, '0, '0);
        send_point(ONE, '0, '0);
        send_point('0, -ONE, '0);
        send_point('0, '0, ONE);
        send_point(ONE, ONE, ONE);
        send_point(MAXC, MAXC, MAXC);
        send_point(MINC, MINC, MINC);
        send_point(MINC, '0, '0);
        send_point(32'd1, 32'd0, 32'd0);
        send_point(32'd1, 32'd1, 32'd0);
        send_point(32'd3, 32'd4, 32'd0);
        send_point(-32'd1, 32'd2, -32'd2);
        write_light(MAXC, MINC, MAXC);
        send_point(MINC, MAXC, MINC);
        send_point(MAXC, MINC, MAXC);
        send_point(MINC, MINC, MINC);
        send_point(MAXC, MAXC, MINC);
        send_point('0, '0, '0);
        write_light(MINC, MINC, MINC);
        send_point(MAXC, MAXC, MAXC);
        send_point(MINC, MINC, MINC);
        send_point(MINC + 1, MINC, MINC);

        write_light($urandom, $urandom, $urandom);
        random_points(380);
        sender_idle_pct = 47;
        receiver_idle_pct = 18;
        write_light(MAXC, MAXC, MAXC);
        random_points(180);
        write_light($urandom_range(65536 * 50), -ONE * 3, ONE * 7);
        random_points(200);
        sender_idle_pct = 0;
        receiver_idle_pct = 0;
        write_light(MINC, MAXC, '0);
        random_points(170);
        write_light($urandom, $urandom, $urandom);
        random_points(200);
        drain_results();

        repeat (40) @(posedge clk);
        $display("covered %0d points and %0d results, %0d of them zero length",
                 sb.points_seen, sb.results_seen, sb.zero_seen);
        $display("light set to both coordinate extremes and random positions");
        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule

/* files.f */
+incdir+hw/rtl
hw/rtl/pld_pkg.sv
hw/rtl/pld_root_step.sv
hw/rtl/point_light_direction.sv
bench/point_light_direction_test.sv
